### sv/stet_pkg.sv
`default_nettype none

package stet_pkg;

   localparam int EVT_W  = 8;
   localparam int DUR_W  = 32;
   localparam int SLOT_W = 4;
   localparam int FIRE_W = 5;

   localparam int MAX_FIRE = 16;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ACTIVATE = 2'd1;
   localparam logic [1:0] OP_SERVICE  = 2'd2;

   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_FIRED = 1'b1;

   typedef struct packed {
      logic load;
      logic walk;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
      logic finish_ok;
   } sts_type;

endpackage

`default_nettype wire

### sv/software_timer_event_table_top.sv
// an activate reply leaves from the finish step, after the walk over the slot rams
// one item at a time: req_stall stays high from transfer until the finish step completes
// fired results leave during the walk, the final one from the finish step
// a stalled result side holds the walk or the finish step and stretches the item
// reset: synchronous, active high; all slots inactive, no clearing pass needed
`default_nettype none

module software_timer_event_table_top #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [stet_pkg::EVT_W-1:0]    req_event_id,
   input  wire logic [stet_pkg::DUR_W-1:0]    req_duration_ms,
   input  wire logic                          req_reset_mode,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_kind,
   output logic      [stet_pkg::SLOT_W-1:0]   rsp_slot,
   output logic      [stet_pkg::EVT_W-1:0]    rsp_fired_event,
   output logic                               rsp_table_full,
   output logic                               rsp_last
);

   stet_pkg::cmd_type cmd;
   stet_pkg::sts_type sts;

   stet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   stet_dp #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_event_id    (req_event_id),
      .req_duration_ms (req_duration_ms),
      .req_reset_mode  (req_reset_mode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_slot        (rsp_slot),
      .rsp_fired_event (rsp_fired_event),
      .rsp_table_full  (rsp_table_full),
      .rsp_last        (rsp_last)
   );

`ifndef ASSERT_OFF
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input side not busy after transfer");

   a_reply_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == stet_pkg::KIND_REPLY) |-> rsp_last)
      else $error("activate reply not marked last");

   a_fired_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == stet_pkg::KIND_FIRED) |-> !rsp_table_full)
      else $error("fired result flagged full");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> (rsp_slot == '0))
      else $error("full reply with nonzero slot");
`endif

endmodule

`default_nettype wire

### sv/stet_ram.sv
`default_nettype none

module stet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/stet_ctrl.sv
`default_nettype none

module stet_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output stet_pkg::cmd_type      cmd,
   input  wire stet_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      FINISH
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      accept;

   assign accept = req_valid && !stall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         stall_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= WALK;
                  stall_ff <= 1'b1;
               end
            end
            WALK: begin
               if (sts.walk_done) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (sts.finish_ok) begin
                  state_ff <= IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall  = stall_ff;
   assign cmd.load   = accept && (state_ff == IDLE);
   assign cmd.walk   = (state_ff == WALK);
   assign cmd.finish = (state_ff == FINISH);

endmodule

`default_nettype wire

### sv/stet_dp.sv
`default_nettype none

module stet_dp #(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stet_pkg::cmd_type             cmd,
   output stet_pkg::sts_type                  sts,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [stet_pkg::EVT_W-1:0]    req_event_id,
   input  wire logic [stet_pkg::DUR_W-1:0]    req_duration_ms,
   input  wire logic                          req_reset_mode,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_kind,
   output logic      [stet_pkg::SLOT_W-1:0]   rsp_slot,
   output logic      [stet_pkg::EVT_W-1:0]    rsp_fired_event,
   output logic                               rsp_table_full,
   output logic                               rsp_last
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   // captured item
   logic [1:0]                 op_ff, op_in;
   logic [stet_pkg::EVT_W-1:0] ev_ff, ev_in;
   logic [stet_pkg::DUR_W-1:0] dur_ff, dur_in;
   logic                       reload_ff, reload_in;

   // walk
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             e_vld_ff, e_vld_in;
   logic [IDX_W-1:0] e_idx_ff, e_idx_in;

   // activate search
   logic             match_fnd_ff, match_fnd_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             free_fnd_ff, free_fnd_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;

   // service
   logic [stet_pkg::FIRE_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic                        hold_vld_ff, hold_vld_in;
   logic [stet_pkg::SLOT_W-1:0] hold_slot_ff, hold_slot_in;
   logic [stet_pkg::EVT_W-1:0]  hold_evt_ff, hold_evt_in;

   logic [NUM_TIMERS-1:0] active_ff, active_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_kind_ff;
   logic [stet_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [stet_pkg::EVT_W-1:0]  rsp_fired_event_ff;
   logic                        rsp_table_full_ff;
   logic                        rsp_last_ff;

   logic                        out_load;
   logic                        out_kind;
   logic [stet_pkg::SLOT_W-1:0] out_slot;
   logic [stet_pkg::EVT_W-1:0]  out_evt;
   logic                        out_full;
   logic                        out_last;
   logic                        out_free;

   logic                        rd_more, cur_act, fire, blocked, adv, rd_en, finish_ok;
   logic [stet_pkg::EVT_W-1:0]  evt_rd, evt_wd;
   logic [stet_pkg::DUR_W-1:0]  rem_rd, rem_wd;
   logic                        evt_we, rem_we;
   logic [IDX_W-1:0]            evt_wa, rem_wa;

   stet_ram #(
      .WIDTH (stet_pkg::EVT_W),
      .DEPTH (NUM_TIMERS)
   ) u_evt_ram (
      .clock   (clock),
      .wr_en   (evt_we),
      .wr_addr (evt_wa),
      .wr_data (evt_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (evt_rd)
   );

   stet_ram #(
      .WIDTH (stet_pkg::DUR_W),
      .DEPTH (NUM_TIMERS)
   ) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_wa),
      .wr_data (rem_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rem_rd)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_more  = (rd_idx_ff < CNT_W'(NUM_TIMERS));
   assign cur_act  = active_ff[e_idx_ff];
   assign fire     = e_vld_ff && (op_ff == stet_pkg::OP_SERVICE) && cur_act &&
                     (rem_rd == '0) &&
                     (fire_cnt_ff < stet_pkg::FIRE_W'(stet_pkg::MAX_FIRE));
   assign blocked  = fire && hold_vld_ff && !out_free;
   assign adv      = cmd.walk && !blocked;
   assign rd_en    = adv && rd_more;
   assign finish_ok = out_free ||
                      !((op_ff == stet_pkg::OP_ACTIVATE) ||
                        ((op_ff == stet_pkg::OP_SERVICE) && hold_vld_ff));

   assign sts.walk_done = cmd.walk && !e_vld_ff && !rd_more;
   assign sts.finish_ok = finish_ok;

   always_comb begin
      op_in        = op_ff;
      ev_in        = ev_ff;
      dur_in       = dur_ff;
      reload_in    = reload_ff;
      rd_idx_in    = rd_idx_ff;
      e_vld_in     = e_vld_ff;
      e_idx_in     = e_idx_ff;
      match_fnd_in = match_fnd_ff;
      match_idx_in = match_idx_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      fire_cnt_in  = fire_cnt_ff;
      hold_vld_in  = hold_vld_ff;
      hold_slot_in = hold_slot_ff;
      hold_evt_in  = hold_evt_ff;
      active_in    = active_ff;

      rem_we   = 1'b0;
      rem_wa   = e_idx_ff;
      rem_wd   = rem_rd - stet_pkg::DUR_W'(1);
      evt_we   = 1'b0;
      evt_wa   = free_idx_ff;
      evt_wd   = ev_ff;

      out_load = 1'b0;
      out_kind = stet_pkg::KIND_REPLY;
      out_slot = '0;
      out_evt  = '0;
      out_full = 1'b0;
      out_last = 1'b1;

      if (cmd.load) begin
         op_in        = req_opcode;
         ev_in        = req_event_id;
         dur_in       = req_duration_ms;
         reload_in    = req_reset_mode;
         rd_idx_in    = '0;
         e_vld_in     = 1'b0;
         match_fnd_in = 1'b0;
         free_fnd_in  = 1'b0;
         fire_cnt_in  = '0;
         hold_vld_in  = 1'b0;
      end else if (adv) begin
         rd_idx_in = rd_idx_ff + CNT_W'(rd_more);
         e_vld_in  = rd_more;
         e_idx_in  = rd_idx_ff[IDX_W-1:0];
         if (e_vld_ff) begin
            case (op_ff)
               stet_pkg::OP_TICK: begin
                  if (cur_act && (rem_rd != '0)) begin
                     rem_we = 1'b1;
                  end
               end
               stet_pkg::OP_ACTIVATE: begin
                  if (cur_act && (evt_rd == ev_ff) && !match_fnd_ff) begin
                     match_fnd_in = 1'b1;
                     match_idx_in = e_idx_ff;
                  end
                  if (!cur_act && !free_fnd_ff) begin
                     free_fnd_in = 1'b1;
                     free_idx_in = e_idx_ff;
                  end
               end
               stet_pkg::OP_SERVICE: begin
                  if (fire) begin
                     active_in[e_idx_ff] = 1'b0;
                     fire_cnt_in  = fire_cnt_ff + stet_pkg::FIRE_W'(1);
                     hold_vld_in  = 1'b1;
                     hold_slot_in = stet_pkg::SLOT_W'(e_idx_ff);
                     hold_evt_in  = evt_rd;
                     if (hold_vld_ff) begin
                        out_load = 1'b1;
                        out_kind = stet_pkg::KIND_FIRED;
                        out_slot = hold_slot_ff;
                        out_evt  = hold_evt_ff;
                        out_last = 1'b0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.finish && finish_ok) begin
         case (op_ff)
            stet_pkg::OP_ACTIVATE: begin
               out_load = 1'b1;
               if (match_fnd_ff) begin
                  rem_we   = reload_ff;
                  rem_wa   = match_idx_ff;
                  rem_wd   = dur_ff;
                  out_slot = stet_pkg::SLOT_W'(match_idx_ff);
               end else if (free_fnd_ff) begin
                  rem_we   = 1'b1;
                  rem_wa   = free_idx_ff;
                  rem_wd   = dur_ff;
                  evt_we   = 1'b1;
                  active_in[free_idx_ff] = 1'b1;
                  out_slot = stet_pkg::SLOT_W'(free_idx_ff);
               end else begin
                  out_full = 1'b1;
               end
            end
            stet_pkg::OP_SERVICE: begin
               if (hold_vld_ff) begin
                  out_load    = 1'b1;
                  out_kind    = stet_pkg::KIND_FIRED;
                  out_slot    = hold_slot_ff;
                  out_evt     = hold_evt_ff;
                  hold_vld_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         e_vld_ff     <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rd_idx_ff    <= '0;
         fire_cnt_ff  <= '0;
         match_fnd_ff <= 1'b0;
         free_fnd_ff  <= 1'b0;
         op_ff        <= stet_pkg::OP_TICK;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         e_vld_ff     <= e_vld_in;
         hold_vld_ff  <= hold_vld_in;
         rd_idx_ff    <= rd_idx_in;
         fire_cnt_ff  <= fire_cnt_in;
         match_fnd_ff <= match_fnd_in;
         free_fnd_ff  <= free_fnd_in;
         op_ff        <= op_in;
      end
      ev_ff        <= ev_in;
      dur_ff       <= dur_in;
      reload_ff    <= reload_in;
      e_idx_ff     <= e_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      hold_slot_ff <= hold_slot_in;
      hold_evt_ff  <= hold_evt_in;
      if (out_load) begin
         rsp_kind_ff        <= out_kind;
         rsp_slot_ff        <= out_slot;
         rsp_fired_event_ff <= out_evt;
         rsp_table_full_ff  <= out_full;
         rsp_last_ff        <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_fired_event = rsp_fired_event_ff;
   assign rsp_table_full  = rsp_table_full_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire
